/* rtl/core/kfc_pkg.sv */
// ----------------------------------------------------------------------------
// kfc_pkg: shared types and constants of the KNX TP frame checker
// Holds the frame snapshot, the result record, check codes and register map.
// ----------------------------------------------------------------------------
package kfc_pkg;

    localparam int MAX_FRAME_DEF = 64;
    localparam int HDR_DEPTH     = 7;
    localparam int LEN_W         = 9;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 8;

    localparam logic [7:0] TYPE_MASK_RST = 8'hD3;
    localparam logic [7:0] STD_CODE_RST  = 8'h90;
    localparam logic [7:0] EXT_CODE_RST  = 8'h10;

    localparam logic [3:0]       LEN_NIBBLE_MASK = 4'hF;
    localparam logic [LEN_W-1:0] STD_LEN_BASE    = 9'd8;
    localparam logic [LEN_W-1:0] EXT_LEN_BASE    = 9'd9;
    localparam logic [7:0]       XOR_GOOD        = 8'hFF;
    localparam int               REPEAT_BIT      = 5;

    typedef enum logic [2:0] {
        CHK_OK       = 3'd0,
        CHK_RX_ERROR = 3'd1,
        CHK_NOT_DATA = 3'd2,
        CHK_LENGTH   = 3'd3,
        CHK_CHECKSUM = 3'd4
    } t_check_code;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TYPE_MASK = 2'd0,
        CFG_STD_CODE  = 2'd1,
        CFG_EXT_CODE  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] type_mask;
        logic [7:0] standard_code;
        logic [7:0] extended_code;
    } t_cfg;

    // Frame state captured on the final octet
    typedef struct packed {
        logic [HDR_DEPTH-1:0][7:0] hdr;
        logic [7:0]                xor_acc;
        logic [LEN_W-1:0]          count;
        logic                      err;
    } t_frame;

    typedef struct packed {
        logic             frame_ok;
        t_check_code      check_code;
        logic             is_extended;
        logic             is_repeat;
        logic             is_group;
        logic [15:0]      source_address;
        logic [15:0]      dest_address;
        logic [LEN_W-1:0] expected_length;
        logic [LEN_W-1:0] received_length;
    } t_result;

endpackage

/* rtl/core/knx_tp_frame_checker.sv */
// ----------------------------------------------------------------------------
// knx_tp_frame_checker: KNX TP1 received frame checker
// Collects frame octets and reports header fields and a verdict per frame.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Ports          | Contents
//  --------+-----------+----------------+----------------------------------------
//  s_axis  | in        | i_s_t*/o_s_t*  | one octet per transaction, tlast on the
//          |           |                | final octet, tuser = receiver error
//  m_axis  | out       | o_m_t*/i_m_t*  | one result per frame (see tdata layout)
//  cfg     | in        | i_cfg_*        | type mask, standard code, extended code
//
//  Cycles: one octet per clock while tready is high. After its final octet is
//  taken, a result passes through the snapshot register and then the result
//  register.
//  Reset: synchronous, active low; clears the frame state, the valid flags
//  and the configuration registers to their defaults.
//  Stalls: the snapshot and result registers form a two-deep pipe, so octets
//  keep flowing while a result waits; tready drops only when both are full
//  and the result is not being taken.
//
module knx_tp_frame_checker import kfc_pkg::*; #(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Octet stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,   // [7:0] byte_value
    input  logic                  i_s_tlast,   // last_byte
    input  logic                  i_s_tuser,   // [0] receiver_error
    // Result stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [0] frame_ok, [3:1] check_code, [4] is_extended, [5] is_repeat,
    // [6] is_group, [22:7] source_address, [38:23] dest_address,
    // [47:39] expected_length, [56:48] received_length, [63:57] zero
    output logic [63:0]           o_m_tdata,
    // Configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg    r_cfg;
    logic    s_acc;
    logic    snap_vld;
    logic    snap_adv;
    t_frame  snap;
    t_result res;
    logic    r_out_vld;
    t_result r_out;

    // Configuration registers: unknown index is ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.type_mask     <= TYPE_MASK_RST;
            r_cfg.standard_code <= STD_CODE_RST;
            r_cfg.extended_code <= EXT_CODE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_TYPE_MASK: r_cfg.type_mask     <= i_cfg_wdata;
                CFG_STD_CODE:  r_cfg.standard_code <= i_cfg_wdata;
                CFG_EXT_CODE:  r_cfg.extended_code <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Advance the snapshot when the result register is free or being drained
    assign snap_adv   = snap_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready = !snap_vld || snap_adv;
    assign s_acc      = i_s_tvalid && o_s_tready;

    kfc_collect #(
        .MAX_FRAME (MAX_FRAME)
    ) u_collect (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (s_acc),
        .i_byte     (i_s_tdata),
        .i_last     (i_s_tlast),
        .i_rerr     (i_s_tuser),
        .i_snap_adv (snap_adv),
        .o_snap_vld (snap_vld),
        .o_snap     (snap)
    );

    kfc_eval u_eval (
        .i_frame (snap),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    // Result register: hold while stalled, load from the snapshot stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (snap_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (snap_adv) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {7'd0,
                         r_out.received_length,
                         r_out.expected_length,
                         r_out.dest_address,
                         r_out.source_address,
                         r_out.is_group,
                         r_out.is_repeat,
                         r_out.is_extended,
                         r_out.check_code,
                         r_out.frame_ok};

endmodule

/* rtl/core/kfc_collect.sv */
// ----------------------------------------------------------------------------
// kfc_collect: per-frame octet collector
// Keeps header octets, running XOR, saturating count and error flag; hands a
// registered snapshot of the frame on its final octet.
// ----------------------------------------------------------------------------
module kfc_collect import kfc_pkg::*; #(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_acc,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  logic       i_rerr,
    input  logic       i_snap_adv,
    output logic       o_snap_vld,
    output t_frame     o_snap
);

    localparam int CNT_W = $clog2(MAX_FRAME + 1);

    logic [HDR_DEPTH-1:0][7:0] r_hdr, n_hdr;
    logic [7:0]                r_xor, n_xor;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic                      r_err, n_err;
    logic                      r_snap_vld;
    t_frame                    r_snap;
    logic                      store;

    // Octets past the frame limit are dropped
    assign store = (r_cnt < CNT_W'(MAX_FRAME));

    always_comb begin
        for (int k = 0; k < HDR_DEPTH; k++) begin
            n_hdr[k] = (store && (r_cnt == CNT_W'(k))) ? i_byte : r_hdr[k];
        end
        n_xor = store ? (r_xor ^ i_byte) : r_xor;
        n_cnt = store ? (r_cnt + CNT_W'(1)) : r_cnt;
        n_err = r_err | i_rerr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr <= '0;
            r_xor <= '0;
            r_cnt <= '0;
            r_err <= 1'b0;
        end else if (i_acc) begin
            if (i_last) begin
                r_hdr <= '0;
                r_xor <= '0;
                r_cnt <= '0;
                r_err <= 1'b0;
            end else begin
                r_hdr <= n_hdr;
                r_xor <= n_xor;
                r_cnt <= n_cnt;
                r_err <= n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_vld <= 1'b0;
        end else if (i_acc && i_last) begin
            r_snap_vld <= 1'b1;
        end else if (i_snap_adv) begin
            r_snap_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc && i_last) begin
            r_snap.hdr     <= n_hdr;
            r_snap.xor_acc <= n_xor;
            r_snap.count   <= LEN_W'(n_cnt);
            r_snap.err     <= n_err;
        end
    end

    assign o_snap_vld = r_snap_vld;
    assign o_snap     = r_snap;

endmodule

/* rtl/core/kfc_eval.sv */
// ----------------------------------------------------------------------------
// kfc_eval: frame verdict logic
// Decodes the header of a frame snapshot and ranks the checks into one code.
// ----------------------------------------------------------------------------
module kfc_eval import kfc_pkg::*; (
    input  t_frame  i_frame,
    input  t_cfg    i_cfg,
    output t_result o_res
);

    logic [7:0]       ctrl;
    logic [7:0]       masked;
    logic             ext;
    logic             data_frame;
    logic [LEN_W-1:0] expect_len;
    t_check_code      code;

    assign ctrl       = i_frame.hdr[0];
    assign masked     = ctrl & i_cfg.type_mask;
    // Extended wins when both codes are equal
    assign ext        = (masked == i_cfg.extended_code);
    assign data_frame = ext || (masked == i_cfg.standard_code);
    assign expect_len = ext ? (EXT_LEN_BASE + LEN_W'(i_frame.hdr[6]))
                            : (STD_LEN_BASE + LEN_W'(i_frame.hdr[5][3:0] & LEN_NIBBLE_MASK));

    always_comb begin
        if (i_frame.err) begin
            code = CHK_RX_ERROR;
        end else if (!data_frame) begin
            code = CHK_NOT_DATA;
        end else if (i_frame.count != expect_len) begin
            code = CHK_LENGTH;
        end else if (i_frame.xor_acc != XOR_GOOD) begin
            code = CHK_CHECKSUM;
        end else begin
            code = CHK_OK;
        end
    end

    always_comb begin
        o_res.frame_ok        = (code == CHK_OK);
        o_res.check_code      = code;
        o_res.is_extended     = ext;
        o_res.is_repeat       = ~ctrl[REPEAT_BIT];
        o_res.expected_length = expect_len;
        o_res.received_length = i_frame.count;
        if (ext) begin
            o_res.source_address = {i_frame.hdr[2], i_frame.hdr[3]};
            o_res.dest_address   = {i_frame.hdr[4], i_frame.hdr[5]};
            o_res.is_group       = i_frame.hdr[1][7];
        end else begin
            o_res.source_address = {i_frame.hdr[1], i_frame.hdr[2]};
            o_res.dest_address   = {i_frame.hdr[3], i_frame.hdr[4]};
            o_res.is_group       = i_frame.hdr[5][7];
        end
    end

endmodule

/* rtl/core/kfc_checker.sv */
// ----------------------------------------------------------------------------
// kfc_checker: port-level checks for the KNX TP frame checker
// Watches the result stream for consistent verdicts and stable stalls.
// ----------------------------------------------------------------------------
module kfc_checker import kfc_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [63:0]           o_m_tdata
);

    // Hold a stalled result transaction unchanged
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed or dropped while stalled");

    // frame_ok agrees with the check code
    a_ok_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[0] == (o_m_tdata[3:1] == CHK_OK)))
        else $error("frame_ok disagrees with check_code");

    // Only the defined check codes appear
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[3:1] == CHK_OK || o_m_tdata[3:1] == CHK_RX_ERROR ||
                        o_m_tdata[3:1] == CHK_NOT_DATA || o_m_tdata[3:1] == CHK_LENGTH ||
                        o_m_tdata[3:1] == CHK_CHECKSUM))
        else $error("undefined check code");

    // Extended frames announce at least nine octets, standard ones at least eight
    a_exp_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[47:39] >= (o_m_tdata[4] ? EXT_LEN_BASE : STD_LEN_BASE)))
        else $error("expected length below header minimum");

    // A frame result never reports a received length of zero
    a_rx_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[56:48] != '0))
        else $error("received length is zero");

endmodule

bind knx_tp_frame_checker kfc_checker u_kfc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
